// ===== hw/rtl/wear_leveled_counter_log_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the wear-leveled counter log
// Clocked on aclk and held off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef WEAR_LEVELED_COUNTER_LOG_TOP_DEFINES_SVH
`define WEAR_LEVELED_COUNTER_LOG_TOP_DEFINES_SVH

// same-cycle implication
`define WLCL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WLCL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wlcl_pkg.sv =====
// ---------------------------------------------------------------------------
// wlcl_pkg
// Shared constants and types of the wear-leveled counter log.
// ---------------------------------------------------------------------------
package wlcl_pkg;

    localparam int NUM_SLOTS  = 128;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int WORD_W     = 32;
    localparam int OUT_SLOT_W = 7;
    localparam int OUT_DATA_W = 48;

    localparam logic [WORD_W-1:0] TAG_MAGIC  = 32'hCAFE_FC01;
    localparam logic [WORD_W-1:0] WORD_EMPTY = 32'hFFFF_FFFF;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SAVE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              erase;
        logic [SLOT_W-1:0] addr;
        logic [WORD_W-1:0] wr_value;
    } mem_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] tag;
    } mem_rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [WORD_W-1:0]     loaded_value;
        logic                  found;
        logic [OUT_SLOT_W-1:0] slot_written;
        logic                  page_erased;
    } res_t;

endpackage

// ===== hw/rtl/wlcl_slot_mem.sv =====
// ---------------------------------------------------------------------------
// wlcl_slot_mem
// Page of slots: one synchronous RAM word per slot (tag and value) with a
// valid flop per slot. An invalid slot reads as erased; a page erase clears
// all valid flops at once, but for that of the slot written in the same cycle.
// ---------------------------------------------------------------------------
module wlcl_slot_mem (
    input  logic              aclk,
    input  logic              aresetn,
    input  wlcl_pkg::mem_req_t mem_req,
    output wlcl_pkg::mem_rsp_t mem_rsp
);
    import wlcl_pkg::*;

    logic [2*WORD_W-1:0] slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [2*WORD_W-1:0] rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            slot_mem[mem_req.addr] <= {TAG_MAGIC, mem_req.wr_value};
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= slot_mem[mem_req.addr];
            rd_vld_reg  <= valid_reg[mem_req.addr];
        end
    end

    always_comb begin
        valid_next = mem_req.erase ? '0 : valid_reg;
        if (mem_req.wr_en) begin
            valid_next[mem_req.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign mem_rsp.value = rd_vld_reg ? rd_data_reg[WORD_W-1:0] : WORD_EMPTY;
    assign mem_rsp.tag   = rd_vld_reg ? rd_data_reg[2*WORD_W-1:WORD_W] : WORD_EMPTY;

endmodule

// ===== hw/rtl/wlcl_ctrl.sv =====
// ---------------------------------------------------------------------------
// wlcl_ctrl
// Scan sequencer: reads one slot per cycle with the check of the previous
// slot overlapped, then writes the chosen slot on a save.
// ---------------------------------------------------------------------------
`include "wear_leveled_counter_log_top_defines.svh"

module wlcl_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_func,
    input  logic [wlcl_pkg::WORD_W-1:0] in_value,
    output wlcl_pkg::mem_req_t        mem_req,
    input  wlcl_pkg::mem_rsp_t        mem_rsp,
    output wlcl_pkg::res_t            res,
    input  logic                      res_ready
);
    import wlcl_pkg::*;

    state_t            state_reg, state_next;
    logic              func_reg, func_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic              pend_reg, pend_next;
    logic              issue_done_reg, issue_done_next;
    logic [WORD_W-1:0] loaded_reg, loaded_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              erased_reg, erased_next;
    logic              blank;

    assign blank    = (mem_rsp.value == WORD_EMPTY) && (mem_rsp.tag == WORD_EMPTY);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        chk_idx_next    = chk_idx_reg;
        pend_next       = pend_reg;
        issue_done_next = issue_done_reg;
        loaded_next     = loaded_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        erased_next     = erased_reg;
        mem_req         = '0;
        mem_req.addr    = idx_reg;
        mem_req.wr_value = value_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    func_next       = in_func;
                    value_next      = in_value;
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    issue_done_next = 1'b0;
                    loaded_next     = '0;
                    hit_next        = 1'b0;
                    slot_next       = '0;
                    erased_next     = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue next read
                if (!issue_done_reg) begin
                    mem_req.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    chk_idx_next  = idx_reg;
                    if (idx_reg == LAST_SLOT) begin
                        issue_done_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
                // check slot read last cycle
                if (pend_reg) begin
                    if (func_reg == FUNC_LOAD) begin
                        if (mem_rsp.tag == TAG_MAGIC) begin
                            loaded_next = mem_rsp.value;
                            hit_next    = 1'b1;
                            if (chk_idx_reg == LAST_SLOT) begin
                                state_next = ST_DONE;
                            end
                        end else if (blank || chk_idx_reg == LAST_SLOT) begin
                            state_next = ST_DONE;
                        end
                    end else begin
                        if (blank) begin
                            slot_next  = chk_idx_reg;
                            state_next = ST_WRITE;
                        end else if (chk_idx_reg == LAST_SLOT) begin
                            slot_next   = '0;
                            erased_next = 1'b1;
                            state_next  = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                mem_req.wr_en = 1'b1;
                mem_req.erase = erased_reg;
                mem_req.addr  = slot_reg;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b0;
            issue_done_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            issue_done_reg <= issue_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        loaded_reg  <= loaded_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        erased_reg  <= erased_next;
    end

    assign res.valid        = (state_reg == ST_DONE);
    assign res.loaded_value = loaded_reg;
    assign res.found        = hit_reg;
    assign res.slot_written = OUT_SLOT_W'(slot_reg);
    assign res.page_erased  = erased_reg;

    `WLCL_ASSERT_NOW(a_erase_slot0, mem_req.erase, mem_req.wr_en && mem_req.addr == '0, "page erase without write to slot zero")
    `WLCL_ASSERT_NEXT(a_write_done, state_reg == ST_WRITE, state_reg == ST_DONE, "write not followed by result")
    `WLCL_ASSERT_NOW(a_load_clean, res.valid && func_reg == FUNC_LOAD, res.slot_written == '0 && !res.page_erased, "load result carries save fields")
    `WLCL_ASSERT_NOW(a_pend_order, state_reg == ST_SCAN && pend_reg && !issue_done_reg, idx_reg == chk_idx_reg + SLOT_W'(1), "read and check out of step")

endmodule

// ===== hw/rtl/wear_leveled_counter_log_top.sv =====
// ---------------------------------------------------------------------------
// wear_leveled_counter_log_top
// Wear-leveled append log of a 32-bit counter in one page of slots.
//
// Channel   Dir  Ports                     Content
// s_        in   tvalid tready tdata tuser  tuser: func; tdata: new_value
// m_        out  tvalid tready tdata        loaded_value found slot_written
//                                           page_erased
//
// One item at a time: a scan reads one slot per cycle from the slot RAM and
// stops at the first blank slot or after the last slot of the page.
// A save ends in a write state; a page erase happens in the same cycle as that write.
// Reset marks every slot erased at once; no clearing pass.
// The result register frees the scanner; a stalled m_ side holds one result
// and then stops the next item at its end.
// ---------------------------------------------------------------------------
module wear_leveled_counter_log_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] new_value
    input  logic [0:0]                      s_tuser,   // [0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wlcl_pkg::OUT_DATA_W-1:0] m_tdata    // [31:0] loaded_value, [32] found,
                                                       // [39:33] slot_written,
                                                       // [40] page_erased, [47:41] zero
);
    import wlcl_pkg::*;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    res_t     res;
    logic     res_ready;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    wlcl_slot_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    wlcl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_value  (s_tdata),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready) begin
            m_tvalid_next = res.valid;
            m_tdata_next  = {7'd0, res.page_erased, res.slot_written, res.found,
                             res.loaded_value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
